// File: rtl/tpdp_pkg.sv
// Package for the ternary packed dot product block.
// Holds widths, weight codes and shared types; it depends on nothing else.
package tpdp_pkg;

    localparam int LANES      = 4;
    localparam int ROWS       = 4;
    localparam int ACT_W      = 16;
    localparam int BYTE_W     = 8;
    localparam int CODE_W     = 2;
    localparam int PROD_W     = ACT_W + 1;
    localparam int LSUM_W     = PROD_W + $clog2(LANES);
    localparam int ACC_W      = 32;
    localparam int GAIN_W     = 16;
    localparam int GAIN_SHIFT = 12;
    localparam int PRODUCT_W  = ACC_W + GAIN_W;
    localparam int SHIFTED_W  = PRODUCT_W - GAIN_SHIFT;

    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(4096);

    typedef enum logic [CODE_W-1:0] {
        CODE_NEG  = 2'd0,
        CODE_ZERO = 2'd1,
        CODE_POS  = 2'd2,
        CODE_TWO  = 2'd3
    } wcode_t;

    typedef logic signed [ACT_W-1:0]  act_t;
    typedef logic [BYTE_W-1:0]        wbyte_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef prod_t [ROWS-1:0]         row_prod_t;
    typedef logic signed [LSUM_W-1:0] lsum_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    typedef struct packed {
        logic valid;
        logic last;
    } stage_ctl_t;

endpackage

// File: rtl/tpdp_if.sv
// Handshake channels of the ternary packed dot product block.
// Depends on tpdp_pkg for field types.
interface tpdp_item_if import tpdp_pkg::*; ();
    logic   valid;
    logic   ready;
    act_t   activation_0;
    act_t   activation_1;
    act_t   activation_2;
    act_t   activation_3;
    wbyte_t weight_byte_0;
    wbyte_t weight_byte_1;
    wbyte_t weight_byte_2;
    wbyte_t weight_byte_3;
    logic   end_of_row;

    modport source (
        output valid, activation_0, activation_1, activation_2, activation_3,
               weight_byte_0, weight_byte_1, weight_byte_2, weight_byte_3, end_of_row,
        input  ready
    );
    modport sink (
        input  valid, activation_0, activation_1, activation_2, activation_3,
               weight_byte_0, weight_byte_1, weight_byte_2, weight_byte_3, end_of_row,
        output ready
    );
endinterface

interface tpdp_result_if import tpdp_pkg::*; ();
    logic valid;
    logic ready;
    acc_t row_result_0;
    acc_t row_result_1;
    acc_t row_result_2;
    acc_t row_result_3;
    logic saturated;

    modport source (
        output valid, row_result_0, row_result_1, row_result_2, row_result_3, saturated,
        input  ready
    );
    modport sink (
        input  valid, row_result_0, row_result_1, row_result_2, row_result_3, saturated,
        output ready
    );
endinterface

// File: rtl/tpdp_lane.sv
// One lane: decodes a packed weight byte and forms one product per row.
// Depends on tpdp_pkg.
module tpdp_lane import tpdp_pkg::*;
(
    input  act_t      activation,
    input  wbyte_t    weight_byte,
    output row_prod_t products
);

    prod_t a_ext;

    assign a_ext = PROD_W'(activation);

    always_comb
    begin
        for (int r = 0; r < ROWS; r++)
        begin
            case (wcode_t'(weight_byte[r*CODE_W +: CODE_W]))
                CODE_NEG:  products[r] = -a_ext;
                CODE_ZERO: products[r] = '0;
                CODE_POS:  products[r] = a_ext;
                CODE_TWO:  products[r] = a_ext <<< 1;
                default:   products[r] = '0;
            endcase
        end
    end

endmodule

// File: rtl/tpdp_merge.sv
// Merging stage: adds the lane products of each row and registers the sums.
// Depends on tpdp_pkg.
module tpdp_merge import tpdp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  logic                     last_in,
    input  row_prod_t [LANES-1:0]    products,
    input  logic                     consume,
    output stage_ctl_t               ctl,
    output lsum_t [ROWS-1:0]         row_sums
);

    logic                    valid_reg, valid_next;
    logic                    last_reg;
    lsum_t [ROWS-1:0]        sums_reg;
    lsum_t [ROWS-1:0]        sums_next;

    always_comb
    begin
        for (int r = 0; r < ROWS; r++)
        begin
            sums_next[r] = '0;
            for (int l = 0; l < LANES; l++)
            begin
                sums_next[r] = sums_next[r] + LSUM_W'(products[l][r]);
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (consume)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sums_reg <= sums_next;
            last_reg <= last_in;
        end
    end

    assign ctl.valid = valid_reg;
    assign ctl.last  = last_reg;
    assign row_sums  = sums_reg;

endmodule

// File: rtl/tpdp_accum.sv
// Row accumulators with saturation, and the register that holds a finished sum.
// Depends on tpdp_pkg.
module tpdp_accum import tpdp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  stage_ctl_t       lane_ctl,
    input  lsum_t [ROWS-1:0] row_sums,
    input  logic             next_free,
    output logic             consume,
    output logic             sum_valid,
    output acc_t [ROWS-1:0]  sums
);

    acc_t [ROWS-1:0] acc_reg, acc_next;
    acc_t [ROWS-1:0] sat_sum;
    acc_t [ROWS-1:0] hold_reg;
    logic            hold_valid_reg, hold_valid_next;
    logic            hold_move;
    logic            hold_free;
    logic [ACC_W:0]  wide [ROWS];

    assign hold_move = hold_valid_reg && next_free;
    assign hold_free = !hold_valid_reg || hold_move;
    assign consume   = lane_ctl.valid && (!lane_ctl.last || hold_free);

    always_comb
    begin
        for (int r = 0; r < ROWS; r++)
        begin
            wide[r] = (ACC_W+1)'(acc_reg[r]) + (ACC_W+1)'(row_sums[r]);
            if (wide[r][ACC_W] != wide[r][ACC_W-1])
            begin
                sat_sum[r] = wide[r][ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                            : {1'b0, {(ACC_W-1){1'b1}}};
            end
            else
            begin
                sat_sum[r] = wide[r][ACC_W-1:0];
            end
        end
    end

    always_comb
    begin
        acc_next        = acc_reg;
        hold_valid_next = hold_valid_reg;
        if (hold_move)
        begin
            hold_valid_next = 1'b0;
        end
        if (consume)
        begin
            if (lane_ctl.last)
            begin
                acc_next        = '0;
                hold_valid_next = 1'b1;
            end
            else
            begin
                acc_next = sat_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg        <= '0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg        <= acc_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume && lane_ctl.last)
        begin
            hold_reg <= sat_sum;
        end
    end

    assign sum_valid = hold_valid_reg;
    assign sums      = hold_reg;

endmodule

// File: rtl/tpdp_scale.sv
// Gain register, gain multipliers, floor shift, saturation and the result register.
// Depends on tpdp_pkg and tpdp_result_if.
module tpdp_scale import tpdp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [GAIN_W-1:0]    cfg_wr_data,
    input  logic                 sum_valid,
    input  acc_t [ROWS-1:0]      sums,
    output logic                 next_free,
    tpdp_result_if.source        result
);

    logic [GAIN_W-1:0]                gain_reg;
    logic                             prod_valid_reg, prod_valid_next;
    logic signed [PRODUCT_W-1:0]      prod_reg [ROWS];
    logic signed [SHIFTED_W-1:0]      shifted [ROWS];
    acc_t [ROWS-1:0]                  res_next;
    acc_t [ROWS-1:0]                  res_reg;
    logic [ROWS-1:0]                  clip;
    logic                             out_valid_reg, out_valid_next;
    logic                             sat_reg;
    logic                             load_prod;
    logic                             prod_move;

    assign prod_move = prod_valid_reg && (!out_valid_reg || result.ready);
    assign next_free = !prod_valid_reg || prod_move;
    assign load_prod = sum_valid && next_free;

    always_comb
    begin
        for (int r = 0; r < ROWS; r++)
        begin
            shifted[r] = SHIFTED_W'(prod_reg[r] >>> GAIN_SHIFT);
            if ((&shifted[r][SHIFTED_W-1:ACC_W-1]) || !(|shifted[r][SHIFTED_W-1:ACC_W-1]))
            begin
                clip[r]     = 1'b0;
                res_next[r] = shifted[r][ACC_W-1:0];
            end
            else
            begin
                clip[r]     = 1'b1;
                res_next[r] = shifted[r][SHIFTED_W-1] ? {1'b1, {(ACC_W-1){1'b0}}}
                                                       : {1'b0, {(ACC_W-1){1'b1}}};
            end
        end
    end

    always_comb
    begin
        prod_valid_next = prod_valid_reg;
        if (load_prod)
        begin
            prod_valid_next = 1'b1;
        end
        else if (prod_move)
        begin
            prod_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (prod_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg       <= GAIN_RESET;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                gain_reg <= cfg_wr_data;
            end
            prod_valid_reg <= prod_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_prod)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                prod_reg[r] <= PRODUCT_W'(sums[r]) * PRODUCT_W'($signed({1'b0, gain_reg}));
            end
        end
        if (prod_move)
        begin
            res_reg <= res_next;
            sat_reg <= |clip;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.row_result_0 = res_reg[0];
    assign result.row_result_1 = res_reg[1];
    assign result.row_result_2 = res_reg[2];
    assign result.row_result_3 = res_reg[3];
    assign result.saturated    = sat_reg;

endmodule

// File: rtl/ternary_packed_dot_product.sv
// An end_of_row request's sums pass the merge, hold, product and result registers.
// Throughput: one request per cycle unless back-pressure stalls; the accumulator add sets it.
// Stages: lane products and merge, accumulator, gain multiply, shift and saturate.
// Reset (rst_n low, asynchronous) clears all valid flags and accumulators, gain to one.
// Depends on tpdp_pkg, tpdp_if and the tpdp_lane, tpdp_merge, tpdp_accum, tpdp_scale modules.
module ternary_packed_dot_product import tpdp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [GAIN_W-1:0] cfg_wr_data,
    tpdp_item_if.sink         item,
    tpdp_result_if.source     result
);

    act_t   [LANES-1:0]      acts;
    wbyte_t [LANES-1:0]      wbytes;
    row_prod_t [LANES-1:0]   products;
    stage_ctl_t              lane_ctl;
    lsum_t [ROWS-1:0]        row_sums;
    acc_t  [ROWS-1:0]        sums;
    logic                    consume;
    logic                    sum_valid;
    logic                    next_free;
    logic                    load;

    assign acts[0]   = item.activation_0;
    assign acts[1]   = item.activation_1;
    assign acts[2]   = item.activation_2;
    assign acts[3]   = item.activation_3;
    assign wbytes[0] = item.weight_byte_0;
    assign wbytes[1] = item.weight_byte_1;
    assign wbytes[2] = item.weight_byte_2;
    assign wbytes[3] = item.weight_byte_3;

    assign item.ready = !lane_ctl.valid || consume;
    assign load       = item.valid && item.ready;

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        tpdp_lane u_lane (
            .activation  (acts[l]),
            .weight_byte (wbytes[l]),
            .products    (products[l])
        );
    end

    tpdp_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .last_in  (item.end_of_row),
        .products (products),
        .consume  (consume),
        .ctl      (lane_ctl),
        .row_sums (row_sums)
    );

    tpdp_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .lane_ctl  (lane_ctl),
        .row_sums  (row_sums),
        .next_free (next_free),
        .consume   (consume),
        .sum_valid (sum_valid),
        .sums      (sums)
    );

    tpdp_scale u_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .sum_valid   (sum_valid),
        .sums        (sums),
        .next_free   (next_free),
        .result      (result)
    );

endmodule
